[rtl/gsd_pkg.sv]
// Shared types, constants and the ln(1+f) table for the shell disassembly step.
// Used by every module of the block; depends on nothing.
`default_nettype none
package gsd_pkg;

   localparam int MAX_FACES_DEF = 64;
   localparam int SLOTS_DEF     = 3;
   localparam int RATE_REGS     = 4;
   localparam int FACE_W        = 6;
   localparam int COUNT_W       = 7;
   localparam int TIME_W        = 48;
   localparam int TOTAL_W       = 40;
   localparam int DT_W          = 37;
   localparam int NEGLOG_W      = 21;
   localparam int REQ_DATA_W    = 80;
   localparam int RSP_DATA_W    = 80;
   localparam logic [15:0] LN2_Q16 = 16'd45426;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
   localparam logic [TIME_W-1:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_STEP  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic [2:0] CSR_RATE_ZERO  = 3'd0;
   localparam logic [2:0] CSR_RATE_ONE   = 3'd1;
   localparam logic [2:0] CSR_RATE_TWO   = 3'd2;
   localparam logic [2:0] CSR_RATE_THREE = 3'd3;
   localparam logic [2:0] CSR_POLY_RATE  = 3'd4;
   localparam logic [2:0] CSR_FACES      = 3'd5;

   localparam logic EVT_LEAVE = 1'b0;
   localparam logic EVT_POLY  = 1'b1;

   typedef enum logic [2:0] {
      PASS_PAIRS = 3'b001,
      PASS_SUM   = 3'b010,
      PASS_PICK  = 3'b100
   } pass_type;

   typedef struct packed {
      logic init;
      logic walk_load;
      logic advance;
   } cell_ctrl_type;

   function automatic logic [15:0] ln_entry(input logic [4:0] k);
      logic [15:0] v;
      case (k)
         5'd0:  v = 16'd0;
         5'd1:  v = 16'd3973;
         5'd2:  v = 16'd7719;
         5'd3:  v = 16'd11262;
         5'd4:  v = 16'd14624;
         5'd5:  v = 16'd17821;
         5'd6:  v = 16'd20870;
         5'd7:  v = 16'd23783;
         5'd8:  v = 16'd26573;
         5'd9:  v = 16'd29248;
         5'd10: v = 16'd31818;
         5'd11: v = 16'd34292;
         5'd12: v = 16'd36675;
         5'd13: v = 16'd38975;
         5'd14: v = 16'd41196;
         5'd15: v = 16'd43345;
         5'd16: v = 16'd45426;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[rtl/gsd_face_cell.sv]
// One face of the shell: in-shell and on-polymer flags plus the walk token.
// Depends on gsd_pkg; chained by the top level, token handed to the next face.
`default_nettype none
module gsd_face_cell import gsd_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          in_use,
   input  wire logic          is_first,
   input  wire logic          prev_token,
   input  wire logic          clr_shell,
   input  wire logic          clr_poly,
   output logic               token_out,
   output logic               shell,
   output logic               poly,
   output logic               sel_shell,
   output logic               sel_poly
);

   logic shell_ff, shell_in;
   logic poly_ff, poly_in;
   logic tok_ff, tok_in;

   always_comb begin
      shell_in = shell_ff;
      poly_in  = poly_ff;
      tok_in   = tok_ff;
      if (ctrl.init) begin
         shell_in = in_use;
         poly_in  = in_use;
      end else begin
         if (clr_shell) begin
            shell_in = 1'b0;
         end
         if (clr_poly) begin
            poly_in = 1'b0;
         end
      end
      if (ctrl.walk_load) begin
         tok_in = is_first;
      end else if (ctrl.advance) begin
         tok_in = prev_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shell_ff <= 1'b1;
         poly_ff  <= 1'b1;
         tok_ff   <= 1'b0;
      end else begin
         shell_ff <= shell_in;
         poly_ff  <= poly_in;
         tok_ff   <= tok_in;
      end
   end

   assign token_out = tok_ff;
   assign shell     = shell_ff;
   assign poly      = poly_ff;
   assign sel_shell = tok_ff & shell_ff;
   assign sel_poly  = tok_ff & poly_ff;

endmodule
`default_nettype wire

[rtl/gsd_time_unit.sv]
// Waiting-time unit: -ln(u1) by normalise, table and interpolation, then a
// restoring divide by the total rate, one quotient bit a cycle. Uses gsd_pkg.
`default_nettype none
module gsd_time_unit import gsd_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [31:0]        u1,
   input  wire logic [TOTAL_W-1:0] den,
   output logic                    done,
   output logic [DT_W-1:0]         dt
);

   typedef enum logic [4:0] {
      T_IDLE  = 5'b00001,
      T_NORM  = 5'b00010,
      T_LNMUL = 5'b00100,
      T_LNSUB = 5'b01000,
      T_DIV   = 5'b10000
   } tstate_type;

   tstate_type state_ff, state_in;
   logic [31:0]        x_ff, x_in;
   logic [4:0]         sh_ff, sh_in;
   logic [15:0]        base_ff, base_in;
   logic [31:0]        prod_ff, prod_in;
   logic [DT_W-1:0]    num_ff, num_in;
   logic [TOTAL_W:0]   rem_ff, rem_in;
   logic [TOTAL_W-1:0] den_ff, den_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               done_ff, done_in;

   logic [4:0]          k;
   logic [15:0]         diff;
   logic [16:0]         lnf;
   logic [21:0]         whole;
   logic [21:0]         neg;
   logic [TOTAL_W:0]    rem_sh;
   logic                qbit;

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      sh_in    = sh_ff;
      base_in  = base_ff;
      prod_in  = prod_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      k        = {1'b0, x_ff[30:27]};
      diff     = ln_entry(k + 5'd1) - ln_entry(k);
      lnf      = {1'b0, base_ff} + {1'b0, prod_ff[31:16]};
      whole    = 22'({1'b0, sh_ff} + 6'd1) * 22'(LN2_Q16);
      neg      = whole - 22'(lnf);
      rem_sh   = {rem_ff[TOTAL_W-1:0], num_ff[DT_W-1]};
      qbit     = rem_sh >= {1'b0, den_ff};
      case (state_ff)
         T_IDLE: begin
            if (start) begin
               x_in     = (u1 == 32'd0) ? 32'd1 : u1;
               sh_in    = 5'd0;
               den_in   = den;
               state_in = T_NORM;
            end
         end
         T_NORM: begin
            if (x_ff[31]) begin
               state_in = T_LNMUL;
            end else begin
               x_in  = {x_ff[30:0], 1'b0};
               sh_in = sh_ff + 5'd1;
            end
         end
         T_LNMUL: begin
            base_in  = ln_entry(k);
            prod_in  = diff * x_ff[26:11];
            state_in = T_LNSUB;
         end
         T_LNSUB: begin
            num_in   = {neg[NEGLOG_W-1:0], 16'd0};
            rem_in   = '0;
            cnt_in   = 6'(DT_W);
            state_in = T_DIV;
         end
         T_DIV: begin
            rem_in = qbit ? (rem_sh - {1'b0, den_ff}) : rem_sh;
            num_in = {num_ff[DT_W-2:0], qbit};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               done_in  = 1'b1;
               state_in = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff    <= x_in;
      sh_ff   <= sh_in;
      base_ff <= base_in;
      prod_ff <= prod_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign dt   = num_ff;

endmodule
`default_nettype wire

[rtl/gillespie_shell_disassembly_step.sv]
// Step item: two table walks over n faces at one neighbour slot a cycle, up to 31
// normalise steps and 37 divide steps. Start item: one table walk over n faces.
// Load and idle operations finish on acceptance, with no walk.
// One item at a time; a finished result waits in the output register.
// Reset (synchronous): all faces flagged in shell and on polymer, counts and time
// zero, rates 1.0, 20 faces; neighbour table undefined until loaded.
`default_nettype none
module gillespie_shell_disassembly_step import gsd_pkg::*; #(
   parameter int MAX_FACES       = MAX_FACES_DEF,
   parameter int NEIGHBOUR_SLOTS = SLOTS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // face_index[5:0] neighbour_slot[7:6] neighbour_face[13:8]
   // neighbour_present[14] uniform_time[46:15] uniform_pick[78:47]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // operation[1:0]
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // chosen_face[5:0] shell_bonds_broken[7:6] polymer_bonds_broken[8]
   // event_time[56:9] faces_remaining[63:57] shell_bonds_remaining[70:64]
   // polymer_bonds_remaining[77:71] all_detached[78]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // event_kind[0]
   output logic                       rsp_tuser,
   input  wire logic                  csr_we,
   input  wire logic [2:0]            csr_index,
   input  wire logic [31:0]           csr_wdata
);

   localparam int DEPTH = MAX_FACES * NEIGHBOUR_SLOTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int FW    = $clog2(MAX_FACES);
   localparam int NW    = $clog2(MAX_FACES + 1);
   localparam int SW    = (NEIGHBOUR_SLOTS > 1) ? $clog2(NEIGHBOUR_SLOTS) : 1;
   localparam int CW    = $clog2(NEIGHBOUR_SLOTS + 1);
   localparam int CMPW  = (NW > COUNT_W) ? NW : COUNT_W;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_INIT   = 8'b0000_0010,
      S_WALK   = 8'b0000_0100,
      S_MUL_LO = 8'b0000_1000,
      S_MUL_HI = 8'b0001_0000,
      S_TARGET = 8'b0010_0000,
      S_TIME   = 8'b0100_0000,
      S_APPLY  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   pass_type  pass_ff, pass_in;

   logic [31:0]        rate_ff [RATE_REGS];
   logic [31:0]        rate_in [RATE_REGS];
   logic [31:0]        prate_ff, prate_in;
   logic [COUNT_W-1:0] fiu_ff, fiu_in;

   logic [FACE_W:0]    nb_mem [DEPTH];
   logic [FACE_W:0]    rd_data_ff;

   logic               iss_on_ff, iss_on_in;
   logic [NW-1:0]      iss_face_ff, iss_face_in;
   logic [SW-1:0]      iss_slot_ff, iss_slot_in;
   logic [AW-1:0]      iss_addr_ff, iss_addr_in;
   logic               rd_v_ff, rd_v_in;
   logic               rd_last_ff, rd_last_in;
   logic [FW-1:0]      rd_face_ff, rd_face_in;
   logic [CW-1:0]      cnt_ff, cnt_in;

   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W-1:0] cum_ff, cum_in;
   logic               any_ff, any_in;
   logic               first_ok_ff, first_ok_in;
   logic [FW-1:0]      first_face_ff, first_face_in;
   logic               first_kind_ff, first_kind_in;
   logic [CW-1:0]      first_cnt_ff, first_cnt_in;
   logic               found_ff, found_in;
   logic [FW-1:0]      pick_face_ff, pick_face_in;
   logic               pick_kind_ff, pick_kind_in;
   logic [CW-1:0]      pick_cnt_ff, pick_cnt_in;

   logic [31:0]        u1_ff, u1_in;
   logic [31:0]        u2_ff, u2_in;
   logic [63:0]        lo_ff, lo_in;
   logic [TOTAL_W-1:0] hi_ff, hi_in;
   logic [TOTAL_W-1:0] target_ff, target_in;
   logic               dt_ok_ff, dt_ok_in;

   logic [TIME_W-1:0]  time_ff, time_in;
   logic [COUNT_W-1:0] sbc_ff, sbc_in;
   logic [COUNT_W-1:0] pbc_ff, pbc_in;
   logic [COUNT_W-1:0] det_ff, det_in;
   logic [COUNT_W-1:0] pairs_ff, pairs_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_kind_ff, rsp_kind_in;

   logic                  accept;
   op_type                op;
   logic [FACE_W-1:0]     in_face;
   logic [1:0]            in_slot;
   logic [NW-1:0]         n_w;
   logic                  ld_ok;
   logic [AW-1:0]         ld_addr;

   logic [MAX_FACES-1:0]  shell_vec, poly_vec, token_vec, sel_shell_vec, sel_poly_vec;
   logic [MAX_FACES-1:0]  clr_shell_vec, clr_poly_vec;
   cell_ctrl_type         cell_ctrl;
   logic                  walk_start;

   logic [FACE_W-1:0]     nb_j;
   logic [FW-1:0]         nb_idx;
   logic                  nb_ok, live, pair;
   logic [CW-1:0]         cnt_now;
   logic [1:0]            rate_idx;
   logic                  cur_shell, cur_poly, face_done;
   logic [TOTAL_W-1:0]    srate_e, prate_e, c1, c2;

   logic                  tu_start, tu_done;
   logic [DT_W-1:0]       tu_dt;
   logic [TIME_W:0]       time_sum;

   logic                  rsp_free, apply_fire;
   logic [FW-1:0]         pf;
   logic                  pk;
   logic [CW-1:0]         pm;
   logic [COUNT_W-1:0]    pm7, sbc_new, pbc_new, det_new;
   logic                  other_flag;
   logic [1:0]            broke;
   logic [CMPW-1:0]       remain_w;

   assign accept     = req_tvalid & req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign op         = op_type'(req_tuser);
   assign in_face    = req_tdata[5:0];
   assign in_slot    = req_tdata[7:6];
   assign n_w        = (int'(fiu_ff) > MAX_FACES) ? NW'(MAX_FACES) : NW'(fiu_ff);
   assign ld_ok      = (int'(in_face) < MAX_FACES) && (int'(in_slot) < NEIGHBOUR_SLOTS);
   assign ld_addr    = AW'(int'(in_face) * NEIGHBOUR_SLOTS + int'(in_slot));

   always_ff @(posedge clock) begin
      if (accept && (op == OP_LOAD) && ld_ok) begin
         nb_mem[ld_addr] <= req_tdata[14:8];
      end
      rd_data_ff <= nb_mem[iss_addr_ff];
   end

   // face cells
   for (genvar i = 0; i < MAX_FACES; i++) begin : g_cell
      gsd_face_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .in_use     (n_w > NW'(i)),
         .is_first   ((i == 0) ? 1'b1 : 1'b0),
         .prev_token ((i == 0) ? 1'b0 : token_vec[(i == 0) ? 0 : i - 1]),
         .clr_shell  (clr_shell_vec[i]),
         .clr_poly   (clr_poly_vec[i]),
         .token_out  (token_vec[i]),
         .shell      (shell_vec[i]),
         .poly       (poly_vec[i]),
         .sel_shell  (sel_shell_vec[i]),
         .sel_poly   (sel_poly_vec[i])
      );
   end

   gsd_time_unit u_time (
      .clock (clock),
      .reset (reset),
      .start (tu_start),
      .u1    (u1_ff),
      .den   (total_ff),
      .done  (tu_done),
      .dt    (tu_dt)
   );

   // neighbour data side of the walk
   assign nb_j      = rd_data_ff[FACE_W-1:0];
   assign nb_idx    = FW'(nb_j);
   assign nb_ok     = rd_data_ff[FACE_W] && (CMPW'(nb_j) < CMPW'(n_w));
   assign live      = nb_ok && shell_vec[nb_idx];
   assign pair      = live && (CMPW'(nb_j) > CMPW'(rd_face_ff));
   assign cnt_now   = cnt_ff + CW'(live);
   assign rate_idx  = (int'(cnt_now) > 3) ? 2'd3 : 2'(cnt_now);
   assign cur_shell = |sel_shell_vec;
   assign cur_poly  = |sel_poly_vec;
   assign face_done = rd_v_ff & rd_last_ff;
   assign srate_e   = cur_shell ? TOTAL_W'(rate_ff[rate_idx]) : '0;
   assign prate_e   = cur_poly ? TOTAL_W'(prate_ff) : '0;
   assign c1        = cum_ff + srate_e;
   assign c2        = c1 + prate_e;
   assign time_sum  = {1'b0, time_ff} + (TIME_W + 1)'(tu_dt);

   // chosen event
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign apply_fire = (state_ff == S_APPLY) && rsp_free;
   assign pf         = found_ff ? pick_face_ff : first_face_ff;
   assign pk         = found_ff ? pick_kind_ff : first_kind_ff;
   assign pm         = found_ff ? pick_cnt_ff : first_cnt_ff;
   assign pm7        = COUNT_W'(pm);
   assign broke      = (int'(pm) > 3) ? 2'd3 : 2'(pm);
   assign other_flag = (pk == EVT_LEAVE) ? poly_vec[pf] : shell_vec[pf];
   assign sbc_new    = (pk == EVT_LEAVE) ? ((pm7 > sbc_ff) ? '0 : sbc_ff - pm7) : sbc_ff;
   assign pbc_new    = ((pk == EVT_POLY) && (pbc_ff != '0)) ? pbc_ff - 7'd1 : pbc_ff;
   assign det_new    = (!other_flag && (det_ff < COUNT_MAX)) ? det_ff + 7'd1 : det_ff;
   assign remain_w   = (CMPW'(det_new) >= CMPW'(n_w)) ? '0 : CMPW'(n_w) - CMPW'(det_new);

   always_comb begin
      clr_shell_vec = '0;
      clr_poly_vec  = '0;
      if (apply_fire) begin
         if (pk == EVT_LEAVE) begin
            clr_shell_vec[pf] = 1'b1;
         end else begin
            clr_poly_vec[pf] = 1'b1;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      pass_in       = pass_ff;
      rate_in       = rate_ff;
      prate_in      = prate_ff;
      fiu_in        = fiu_ff;
      iss_on_in     = iss_on_ff;
      iss_face_in   = iss_face_ff;
      iss_slot_in   = iss_slot_ff;
      iss_addr_in   = iss_addr_ff;
      rd_v_in       = 1'b0;
      rd_last_in    = rd_last_ff;
      rd_face_in    = rd_face_ff;
      cnt_in        = cnt_ff;
      total_in      = total_ff;
      cum_in        = cum_ff;
      any_in        = any_ff;
      first_ok_in   = first_ok_ff;
      first_face_in = first_face_ff;
      first_kind_in = first_kind_ff;
      first_cnt_in  = first_cnt_ff;
      found_in      = found_ff;
      pick_face_in  = pick_face_ff;
      pick_kind_in  = pick_kind_ff;
      pick_cnt_in   = pick_cnt_ff;
      u1_in         = u1_ff;
      u2_in         = u2_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      target_in     = target_ff;
      dt_ok_in      = dt_ok_ff | tu_done;
      time_in       = time_ff;
      sbc_in        = sbc_ff;
      pbc_in        = pbc_ff;
      det_in        = det_ff;
      pairs_in      = pairs_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_kind_in   = rsp_kind_ff;
      walk_start    = 1'b0;
      tu_start      = 1'b0;
      cell_ctrl     = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_RATE_ZERO:  rate_in[0] = csr_wdata;
            CSR_RATE_ONE:   rate_in[1] = csr_wdata;
            CSR_RATE_TWO:   rate_in[2] = csr_wdata;
            CSR_RATE_THREE: rate_in[3] = csr_wdata;
            CSR_POLY_RATE:  prate_in   = csr_wdata;
            CSR_FACES:      fiu_in     = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end

      // issue side of the walk
      if (iss_on_ff) begin
         if (iss_face_ff < n_w) begin
            rd_v_in     = 1'b1;
            rd_last_in  = (int'(iss_slot_ff) == NEIGHBOUR_SLOTS - 1);
            rd_face_in  = FW'(iss_face_ff);
            iss_addr_in = iss_addr_ff + AW'(1);
            if (int'(iss_slot_ff) == NEIGHBOUR_SLOTS - 1) begin
               iss_slot_in = '0;
               iss_face_in = iss_face_ff + NW'(1);
            end else begin
               iss_slot_in = iss_slot_ff + SW'(1);
            end
         end else begin
            iss_on_in = 1'b0;
         end
      end

      // data side of the walk
      if (rd_v_ff) begin
         cnt_in = face_done ? '0 : cnt_now;
         if ((pass_ff == PASS_PAIRS) && pair && (pairs_ff < COUNT_MAX)) begin
            pairs_in = pairs_ff + 7'd1;
         end
      end
      if (face_done) begin
         cell_ctrl.advance = 1'b1;
         if (pass_ff == PASS_SUM) begin
            total_in = total_ff + srate_e + prate_e;
            if (cur_shell || cur_poly) begin
               any_in = 1'b1;
            end
            if (!first_ok_ff && (cur_shell || cur_poly)) begin
               first_ok_in   = 1'b1;
               first_face_in = rd_face_ff;
               first_kind_in = cur_shell ? EVT_LEAVE : EVT_POLY;
               first_cnt_in  = cnt_now;
            end
         end else if (pass_ff == PASS_PICK) begin
            cum_in = c2;
            if (!found_ff) begin
               if (cur_shell && (c1 >= target_ff)) begin
                  found_in     = 1'b1;
                  pick_face_in = rd_face_ff;
                  pick_kind_in = EVT_LEAVE;
                  pick_cnt_in  = cnt_now;
               end else if (cur_poly && (c2 >= target_ff)) begin
                  found_in     = 1'b1;
                  pick_face_in = rd_face_ff;
                  pick_kind_in = EVT_POLY;
                  pick_cnt_in  = cnt_now;
               end
            end
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (op)
                  OP_START: state_in = S_INIT;
                  OP_STEP: begin
                     u1_in       = req_tdata[46:15];
                     u2_in       = req_tdata[78:47];
                     total_in    = '0;
                     any_in      = 1'b0;
                     first_ok_in = 1'b0;
                     pass_in     = PASS_SUM;
                     walk_start  = 1'b1;
                     state_in    = S_WALK;
                  end
                  default: ;
               endcase
            end
         end
         S_INIT: begin
            cell_ctrl.init = 1'b1;
            time_in    = '0;
            pbc_in     = COUNT_W'(n_w);
            det_in     = '0;
            pairs_in   = '0;
            pass_in    = PASS_PAIRS;
            walk_start = 1'b1;
            state_in   = S_WALK;
         end
         S_WALK: begin
            if (!iss_on_ff && !rd_v_ff) begin
               case (pass_ff)
                  PASS_PAIRS: begin
                     sbc_in   = pairs_ff;
                     state_in = S_IDLE;
                  end
                  PASS_SUM: begin
                     if (any_ff) begin
                        tu_start = (total_ff != '0);
                        dt_ok_in = 1'b0;
                        state_in = S_MUL_LO;
                     end else begin
                        state_in = S_IDLE;
                     end
                  end
                  default: state_in = S_APPLY;
               endcase
            end
         end
         S_MUL_LO: begin
            lo_in    = u2_ff * total_ff[31:0];
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            hi_in    = TOTAL_W'(u2_ff * total_ff[TOTAL_W-1:32]);
            state_in = S_TARGET;
         end
         S_TARGET: begin
            target_in = hi_ff + TOTAL_W'(lo_ff[63:32]) + TOTAL_W'(lo_ff[31:0] != 32'd0);
            state_in  = S_TIME;
         end
         S_TIME: begin
            if ((total_ff == '0) || dt_ok_ff) begin
               if (total_ff == '0) begin
                  time_in = TIME_MAX;
               end else begin
                  time_in = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
               end
               cum_in     = '0;
               found_in   = 1'b0;
               pass_in    = PASS_PICK;
               walk_start = 1'b1;
               state_in   = S_WALK;
            end
         end
         S_APPLY: begin
            if (rsp_free) begin
               sbc_in       = sbc_new;
               pbc_in       = pbc_new;
               det_in       = det_new;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pk;
               rsp_data_in  = {1'b0,
                               (CMPW'(det_new) >= CMPW'(n_w)),
                               pbc_new,
                               sbc_new,
                               COUNT_W'(remain_w),
                               time_ff,
                               (pk == EVT_POLY),
                               (pk == EVT_LEAVE) ? broke : 2'd0,
                               FACE_W'(pf)};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (walk_start) begin
         cell_ctrl.walk_load = 1'b1;
         iss_on_in   = 1'b1;
         iss_face_in = '0;
         iss_slot_in = '0;
         iss_addr_in = '0;
         cnt_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pass_ff      <= PASS_SUM;
         for (int r = 0; r < RATE_REGS; r++) begin
            rate_ff[r] <= 32'd65536;
         end
         prate_ff     <= 32'd65536;
         fiu_ff       <= 7'd20;
         iss_on_ff    <= 1'b0;
         rd_v_ff      <= 1'b0;
         cnt_ff       <= '0;
         time_ff      <= '0;
         sbc_ff       <= '0;
         pbc_ff       <= '0;
         det_ff       <= '0;
         dt_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rate_ff      <= rate_in;
         prate_ff     <= prate_in;
         fiu_ff       <= fiu_in;
         iss_on_ff    <= iss_on_in;
         rd_v_ff      <= rd_v_in;
         cnt_ff       <= cnt_in;
         time_ff      <= time_in;
         sbc_ff       <= sbc_in;
         pbc_ff       <= pbc_in;
         det_ff       <= det_in;
         dt_ok_ff     <= dt_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      iss_face_ff   <= iss_face_in;
      iss_slot_ff   <= iss_slot_in;
      iss_addr_ff   <= iss_addr_in;
      rd_last_ff    <= rd_last_in;
      rd_face_ff    <= rd_face_in;
      total_ff      <= total_in;
      cum_ff        <= cum_in;
      any_ff        <= any_in;
      first_ok_ff   <= first_ok_in;
      first_face_ff <= first_face_in;
      first_kind_ff <= first_kind_in;
      first_cnt_ff  <= first_cnt_in;
      found_ff      <= found_in;
      pick_face_ff  <= pick_face_in;
      pick_kind_ff  <= pick_kind_in;
      pick_cnt_ff   <= pick_cnt_in;
      u1_ff         <= u1_in;
      u2_ff         <= u2_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      target_ff     <= target_in;
      pairs_ff      <= pairs_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_kind_ff   <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule
`default_nettype wire

[rtl/gsd_checker.sv]
// Port-level checks for the shell disassembly step, bound to the top level.
// Depends on gsd_pkg for field widths.
`default_nettype none
module gsd_checker import gsd_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   a_poly_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[8] == rsp_tuser))
      else $error("polymer bond count disagrees with event kind");

   a_shell_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[7:6] != 2'd0) |-> (rsp_tuser == EVT_LEAVE))
      else $error("shell bonds broken by a polymer event");

   a_detached: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[78] |-> (rsp_tdata[63:57] == 7'd0))
      else $error("faces remain while all detached");

endmodule

bind gillespie_shell_disassembly_step gsd_checker u_gsd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for gillespie_shell_disassembly_step: drives load, start and step items
// over the stream ports and checks every event against a built-in predictor.
// Depends on gsd_pkg and the block's RTL only.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gsd_pkg::*;

   typedef struct packed {
      logic [5:0]  face;
      logic        kind;
      logic [1:0]  shell_broken;
      logic        poly_broken;
      logic [47:0] stamp;
      logic [6:0]  remaining;
      logic [6:0]  shell_left;
      logic [6:0]  poly_left;
      logic        all_gone;
   } shell_event_t;

   class shell_scoreboard;
      bit [15:0]    ln_q16[17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783,
                                   26573, 29248, 31818, 34292, 36675, 38975, 41196,
                                   43345, 45426};
      bit [5:0]     nb_face[192];
      bit           nb_here[192];
      bit           in_shell[64];
      bit           on_poly[64];
      bit [47:0]    clock_now;
      int           shell_bonds, poly_bonds, detached;
      bit [31:0]    leave_rate[4];
      bit [31:0]    poly_rate;
      bit [6:0]     faces;
      shell_event_t pending_events[$];
      int           errors;

      function void reset_state();
         foreach (in_shell[i]) begin
            in_shell[i] = 1;
            on_poly[i] = 1;
         end
         clock_now = 0;
         shell_bonds = 0;
         poly_bonds = 0;
         detached = 0;
         foreach (leave_rate[i]) leave_rate[i] = 32'h10000;
         poly_rate = 32'h10000;
         faces = 7'd20;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         if (idx < CSR_POLY_RATE) leave_rate[idx] = val;
         else if (idx == CSR_POLY_RATE) poly_rate = val;
         else if (idx == CSR_FACES) faces = val[6:0];
      endfunction

      function int face_count();
         return faces > 64 ? 64 : faces;
      endfunction

      function int live_neighbours(int f, int n);
         int c;
         c = 0;
         for (int s = 0; s < 3; s++)
            if (nb_here[f*3+s] && nb_face[f*3+s] < n && in_shell[nb_face[f*3+s]]) c++;
         return c;
      endfunction

      function bit [31:0] leave_rate_of(int f, int n);
         int m;
         m = live_neighbours(f, n);
         return leave_rate[m > 3 ? 3 : m];
      endfunction

      function bit [63:0] neg_log(bit [31:0] x);
         int p;
         bit [31:0] m;
         bit [3:0] k;
         bit [15:0] w;
         bit [63:0] lnf;
         if (x == 0) x = 1;
         p = 31;
         while (!x[p]) p--;
         m = x << (31 - p);
         k = m[30:27];
         w = m[26:11];
         lnf = ln_q16[k] + ((64'(ln_q16[k+1] - ln_q16[k]) * w) >> 16);
         return 64'(32 - p) * 45426 - lnf;
      endfunction

      function void note_item(op_type op, logic [5:0] face, logic [1:0] slot,
                              logic [5:0] nface, logic present, logic [31:0] u1,
                              logic [31:0] u2);
         int n, pairs, pick, m;
         bit kind, found;
         bit [63:0] total, dt, target, cum;
         bit [127:0] prod;
         shell_event_t ev;
         n = face_count();
         case (op)
            OP_LOAD: begin
               if (slot < 3) begin
                  nb_face[face*3+slot] = nface;
                  nb_here[face*3+slot] = present;
               end
            end
            OP_START: begin
               pairs = 0;
               for (int i = 0; i < 64; i++) begin
                  in_shell[i] = i < n;
                  on_poly[i] = i < n;
               end
               for (int i = 0; i < n; i++)
                  for (int s = 0; s < 3; s++)
                     if (nb_here[i*3+s] && nb_face[i*3+s] > i && nb_face[i*3+s] < n
                         && pairs < 127) pairs++;
               shell_bonds = pairs;
               poly_bonds = n;
               detached = 0;
               clock_now = 0;
            end
            OP_STEP: begin
               total = 0;
               found = 0;
               for (int i = 0; i < n; i++) begin
                  if (in_shell[i]) begin total += leave_rate_of(i, n); found = 1; end
                  if (on_poly[i]) begin total += poly_rate; found = 1; end
               end
               if (!found) return;
               if (total == 0) clock_now = TIME_MAX;
               else begin
                  dt = (neg_log(u1) << 16) / total;
                  clock_now = (dt > 64'(TIME_MAX - clock_now)) ? TIME_MAX
                              : clock_now + dt[47:0];
               end
               prod = 128'(u2) * 128'(total);
               target = prod[95:32] + (prod[31:0] != 0);
               cum = 0;
               found = 0;
               pick = 0;
               kind = EVT_LEAVE;
               for (int i = 0; i < n && !found; i++) begin
                  if (in_shell[i]) begin
                     cum += leave_rate_of(i, n);
                     if (cum >= target) begin pick = i; kind = EVT_LEAVE; found = 1; end
                  end
                  if (!found && on_poly[i]) begin
                     cum += poly_rate;
                     if (cum >= target) begin pick = i; kind = EVT_POLY; found = 1; end
                  end
               end
               for (int i = 0; i < n && !found; i++) begin
                  if (in_shell[i]) begin pick = i; kind = EVT_LEAVE; found = 1; end
                  else if (on_poly[i]) begin pick = i; kind = EVT_POLY; found = 1; end
               end
               ev = '0;
               if (kind == EVT_LEAVE) begin
                  m = live_neighbours(pick, n);
                  ev.shell_broken = 2'(m > 3 ? 3 : m);
                  shell_bonds = m > shell_bonds ? 0 : shell_bonds - m;
                  in_shell[pick] = 0;
               end else begin
                  ev.poly_broken = 1;
                  if (poly_bonds > 0) poly_bonds--;
                  on_poly[pick] = 0;
               end
               if (!in_shell[pick] && !on_poly[pick] && detached < 127) detached++;
               ev.face = 6'(pick);
               ev.kind = kind;
               ev.stamp = clock_now;
               ev.remaining = 7'(detached >= n ? 0 : n - detached);
               ev.shell_left = 7'(shell_bonds);
               ev.poly_left = 7'(poly_bonds);
               ev.all_gone = (detached >= n);
               pending_events = {pending_events, ev};
            end
            default: ;
         endcase
      endfunction

      function void check_event(shell_event_t got);
         shell_event_t want;
         if (pending_events.size() == 0) begin
            $error("event with nothing expected: %p", got);
            errors++;
            return;
         end
         want = pending_events.pop_front();
         if (got.face !== want.face) begin
            $error("chosen_face exp %0d got %0d", want.face, got.face); errors++; end
         if (got.kind !== want.kind) begin
            $error("event_kind exp %0d got %0d", want.kind, got.kind); errors++; end
         if (got.shell_broken !== want.shell_broken) begin
            $error("shell_bonds_broken exp %0d got %0d", want.shell_broken,
                   got.shell_broken); errors++; end
         if (got.poly_broken !== want.poly_broken) begin
            $error("polymer_bonds_broken exp %0d got %0d", want.poly_broken,
                   got.poly_broken); errors++; end
         if (got.stamp !== want.stamp) begin
            $error("event_time exp %0h got %0h", want.stamp, got.stamp); errors++; end
         if (got.remaining !== want.remaining) begin
            $error("faces_remaining exp %0d got %0d", want.remaining, got.remaining);
            errors++; end
         if (got.shell_left !== want.shell_left) begin
            $error("shell_bonds_remaining exp %0d got %0d", want.shell_left,
                   got.shell_left); errors++; end
         if (got.poly_left !== want.poly_left) begin
            $error("polymer_bonds_remaining exp %0d got %0d", want.poly_left,
                   got.poly_left); errors++; end
         if (got.all_gone !== want.all_gone) begin
            $error("all_detached exp %0d got %0d", want.all_gone, got.all_gone);
            errors++; end
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = OP_NONE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we = 0;
   logic [2:0]            csr_index = '0;
   logic [31:0]           csr_wdata = '0;

   shell_scoreboard board = new();
   bit calm = 0;
   int items_sent = 0;

   gillespie_shell_disassembly_step dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   initial begin
      #60_000_000;
      $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_event({rsp_tdata[5:0], rsp_tuser, rsp_tdata[7:6], rsp_tdata[8],
                            rsp_tdata[56:9], rsp_tdata[63:57], rsp_tdata[70:64],
                            rsp_tdata[77:71], rsp_tdata[78]});
      rsp_tready <= calm || $urandom_range(0, 99) >= 11;
   end

   task automatic send_item(op_type op, logic [5:0] face = 0, logic [1:0] slot = 0,
                            logic [5:0] nface = 0, logic present = 0,
                            logic [31:0] u1 = $urandom, logic [31:0] u2 = $urandom);
      while (!calm && $urandom_range(0, 99) < 11) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {1'b0, u2, u1, present, nface, slot, face};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_item(op, face, slot, nface, present, u1, u2);
      items_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.pending_events.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic write_regs(logic [31:0] r0, logic [31:0] r1, logic [31:0] r2,
                             logic [31:0] r3, logic [31:0] rp, logic [6:0] nf);
      logic [31:0] vals[6];
      vals = '{r0, r1, r2, r3, rp, 32'(nf)};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         board.write_reg(3'(i), vals[i]);
      end
      csr_we <= 0;
   endtask

   function automatic logic [31:0] pick_rate();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return 0;
      if (r < 10) return 32'hFFFF_FFFF;
      if (r < 20) return $urandom;
      return $urandom_range(1, 32'h40000);
   endfunction

   task automatic load_random(int f, int s);
      send_item(OP_LOAD, f, s, $urandom_range(0, 99) < 85 ? $urandom_range(0, 20)
                : $urandom_range(0, 63), $urandom_range(0, 3) != 0);
   endtask

   initial begin
      int n, steps;
      board.reset_state();
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // fill the whole neighbour table so that no unloaded entry is ever read
      for (int f = 0; f < 64; f++)
         for (int s = 0; s < 3; s++) load_random(f, s);

      // directed items
      send_item(OP_LOAD, 63, 3, 63, 1);
      send_item(OP_LOAD, 5, 0, 5, 1);
      send_item(OP_NONE);
      send_item(OP_STEP);
      send_item(OP_START);
      send_item(OP_STEP, 0, 0, 0, 0, 32'h0, 32'h0);
      send_item(OP_STEP, 0, 0, 0, 0, 32'h1, 32'hFFFF_FFFF);
      send_item(OP_STEP, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000);
      send_item(OP_STEP, 63, 3, 63, 1, 32'h8000_0000, 32'h0);
      settle();
      write_regs(0, 0, 0, 0, 0, 7'd64);
      send_item(OP_START);
      send_item(OP_STEP);
      send_item(OP_STEP);
      settle();
      write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 7'd127);
      send_item(OP_START);
      send_item(OP_STEP, 0, 0, 0, 0, 32'h0, 32'hFFFF_FFFF);
      send_item(OP_STEP, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h0);
      settle();
      write_regs(32'h10000, 0, 32'h10000, 32'hFFFF_FFFF, 0, 7'd1);
      send_item(OP_START);
      send_item(OP_STEP);
      send_item(OP_STEP);
      send_item(OP_STEP);

      // random trajectories
      while (items_sent < 800) begin
         settle();
         calm = items_sent > 500 && items_sent < 650;
         case ($urandom_range(0, 19))
            0:       n = 0;
            1, 2:    n = $urandom_range(64, 127);
            3, 4, 5: n = $urandom_range(13, 40);
            default: n = $urandom_range(1, 12);
         endcase
         write_regs(pick_rate(), pick_rate(), pick_rate(), pick_rate(), pick_rate(), n);
         repeat ($urandom_range(0, 6)) load_random($urandom_range(0, 63), $urandom_range(0, 3));
         if ($urandom_range(0, 9) != 0) send_item(OP_START);
         steps = (n > 64 ? 128 : 2 * n) + $urandom_range(0, 2);
         if (n > 24) steps = steps / 2;
         repeat (steps) begin
            case ($urandom_range(0, 19))
               0:       send_item(OP_NONE);
               1:       load_random($urandom_range(0, 63), $urandom_range(0, 3));
               default: send_item(OP_STEP);
            endcase
         end
      end

      req_tvalid <= 0;
      @(posedge clock);
      while (board.pending_events.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (board.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire
